// ===== src/ncv_pkg.sv =====
// Package for the NMEA sentence checksum verifier.
// Types, character constants and the hex digit decoder; no dependencies.
package ncv_pkg;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [3:0] MIN_LEN   = 4'd8;
    localparam logic [4:0] NIB_BAD   = 5'd16;

    typedef enum logic [4:0] {
        PH_START = 5'b00001,
        PH_BODY  = 5'b00010,
        PH_DIG1  = 5'b00100,
        PH_DIG2  = 5'b01000,
        PH_TAIL  = 5'b10000
    } t_phase;

    typedef enum logic [2:0] {
        RSN_OK       = 3'd0,
        RSN_SHORT    = 3'd1,
        RSN_NODOLLAR = 3'd2,
        RSN_NOSTAR   = 3'd3,
        RSN_BADHEX   = 3'd4,
        RSN_MISMATCH = 3'd5
    } t_reason;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_sentence;
    } t_in_item;

    typedef struct packed {
        logic       sentence_ok;
        t_reason    reason;
        logic [7:0] computed_sum;
        logic [7:0] provided_sum;
    } t_verdict;

    // 0..15 for a hex digit, NIB_BAD otherwise
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        logic [4:0] nib;
        nib = NIB_BAD;
        if (c >= 8'h30 && c <= 8'h39) begin
            nib = {1'b0, 4'(c - 8'h30)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            nib = {1'b0, 4'(c - 8'h41 + 8'd10)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            nib = {1'b0, 4'(c - 8'h61 + 8'd10)};
        end
        return nib;
    endfunction

endpackage

// ===== src/ncv_in_if.sv =====
// Input channel of the checksum verifier: one sentence byte per item.
// Depends on ncv_pkg.
interface ncv_in_if import ncv_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_sentence;

    modport source (output valid, output data_byte, output end_of_sentence, input ready);
    modport sink   (input valid, input data_byte, input end_of_sentence, output ready);
endinterface

// ===== src/ncv_out_if.sv =====
// Output channel of the checksum verifier: one verdict per sentence.
// Depends on ncv_pkg.
interface ncv_out_if import ncv_pkg::*; ();
    logic       valid;
    logic       ready;
    logic       sentence_ok;
    logic [2:0] reason;
    logic [7:0] computed_sum;
    logic [7:0] provided_sum;

    modport source (output valid, output sentence_ok, output reason,
                    output computed_sum, output provided_sum, input ready);
    modport sink   (input valid, input sentence_ok, input reason,
                    input computed_sum, input provided_sum, output ready);
endinterface

// ===== src/ncv_in_reg.sv =====
// Input register of the checksum verifier: holds one accepted byte item.
// Depends on ncv_pkg and ncv_in_if.
module ncv_in_reg import ncv_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ncv_in_if.sink     i_sent,
    input  logic       i_take,
    output logic       o_vld,
    output t_in_item   o_item
);
    logic     r_vld;
    t_in_item r_item;

    assign i_sent.ready = !r_vld || i_take;
    assign o_vld  = r_vld;
    assign o_item = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_sent.ready) begin
            r_vld <= i_sent.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_sent.valid && i_sent.ready) begin
            r_item <= '{data_byte: i_sent.data_byte,
                        end_of_sentence: i_sent.end_of_sentence};
        end
    end
endmodule

// ===== src/ncv_scan.sv =====
// Sentence scanner: phase, running XOR, digit value and length state,
// plus the verdict logic on the last byte. Depends on ncv_pkg.
module ncv_scan import ncv_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_vld,
    input  t_in_item   i_item,
    input  logic       i_out_free,
    output logic       o_take,
    output logic       o_res_vld,
    output t_verdict   o_res
);
    t_phase     r_phase,  n_phase;
    logic [7:0] r_xor,    n_xor;
    logic [7:0] r_digits, n_digits;
    logic [3:0] r_count,  n_count;
    logic       r_start_bad, n_start_bad;
    logic       r_hex_bad,   n_hex_bad;
    logic [4:0] nib;
    logic [7:0] provided;
    t_reason    reason;

    always_comb begin
        n_phase     = r_phase;
        n_xor       = r_xor;
        n_digits    = r_digits;
        n_start_bad = r_start_bad;
        n_hex_bad   = r_hex_bad;
        n_count     = (r_count < MIN_LEN) ? r_count + 4'd1 : r_count;
        nib         = hex_nibble(i_item.data_byte);
        case (r_phase)
            PH_START: begin
                n_start_bad = (i_item.data_byte != CH_DOLLAR);
                n_phase     = PH_BODY;
            end
            PH_BODY: begin
                if (i_item.data_byte == CH_STAR) n_phase = PH_DIG1;
                else n_xor = r_xor ^ i_item.data_byte;
            end
            PH_DIG1: begin
                if (nib[4]) n_hex_bad = 1'b1;
                n_digits = nib[4] ? 8'h00 : {nib[3:0], 4'h0};
                n_phase  = PH_DIG2;
            end
            PH_DIG2: begin
                if (nib[4]) n_hex_bad = 1'b1;
                n_digits = nib[4] ? r_digits : (r_digits | {4'h0, nib[3:0]});
                n_phase  = PH_TAIL;
            end
            default: begin
                n_phase = PH_TAIL;
            end
        endcase
    end

    always_comb begin
        provided = (n_phase == PH_TAIL) ? n_digits : 8'h00;
        if (n_count < MIN_LEN)       reason = RSN_SHORT;
        else if (n_start_bad)        reason = RSN_NODOLLAR;
        else if (n_phase != PH_TAIL) reason = RSN_NOSTAR;
        else if (n_hex_bad)          reason = RSN_BADHEX;
        else if (n_xor != provided)  reason = RSN_MISMATCH;
        else                         reason = RSN_OK;
    end

    // a last byte waits until the result register has room
    assign o_take    = i_vld && (!i_item.end_of_sentence || i_out_free);
    assign o_res_vld = i_vld && i_item.end_of_sentence && i_out_free;
    assign o_res     = '{sentence_ok: (reason == RSN_OK), reason: reason,
                         computed_sum: n_xor, provided_sum: provided};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (o_take && i_item.end_of_sentence)) begin
            r_phase     <= PH_START;
            r_xor       <= 8'h00;
            r_digits    <= 8'h00;
            r_count     <= 4'd0;
            r_start_bad <= 1'b0;
            r_hex_bad   <= 1'b0;
        end else if (o_take) begin
            r_phase     <= n_phase;
            r_xor       <= n_xor;
            r_digits    <= n_digits;
            r_count     <= n_count;
            r_start_bad <= n_start_bad;
            r_hex_bad   <= n_hex_bad;
        end
    end
endmodule

// ===== src/ncv_out_reg.sv =====
// Result register of the checksum verifier: holds one verdict item.
// Depends on ncv_pkg and ncv_out_if.
module ncv_out_reg import ncv_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  t_verdict   i_res,
    output logic       o_free,
    ncv_out_if.source  o_verdict
);
    logic     r_vld;
    t_verdict r_res;

    assign o_free = !r_vld || o_verdict.ready;

    assign o_verdict.valid        = r_vld;
    assign o_verdict.sentence_ok  = r_res.sentence_ok;
    assign o_verdict.reason       = r_res.reason;
    assign o_verdict.computed_sum = r_res.computed_sum;
    assign o_verdict.provided_sum = r_res.provided_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_free) begin
            r_vld <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end
endmodule

// ===== src/nmea_sentence_checksum_verify.sv =====
// Top level of the NMEA sentence checksum verifier.
// Depends on ncv_pkg, ncv_in_if, ncv_out_if, ncv_in_reg, ncv_scan, ncv_out_reg.
//
//   channel    dir  payload                                        per
//   i_sent     in   data_byte[7:0], end_of_sentence                 byte
//   o_verdict  out  sentence_ok, reason[2:0], computed_sum[7:0],    sentence
//                   provided_sum[7:0]
//
// One byte item per cycle while the input is not held off. The last byte of a
// sentence is held in the input register, and its verdict is loaded into the
// result register once that has room, from where it is offered on o_verdict.
// Synchronous active-low reset empties both registers and clears the scanner.
// While the result register is full and not taken, a last byte waits in the
// input register and holds off the input; other bytes keep flowing.
// Ready depends combinationally on o_verdict.ready.
module nmea_sentence_checksum_verify import ncv_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ncv_in_if.sink     i_sent,
    ncv_out_if.source  o_verdict
);
    logic     item_vld;
    t_in_item item;
    logic     take;
    logic     out_free;
    logic     res_vld;
    t_verdict res;

    ncv_in_reg u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sent  (i_sent),
        .i_take  (take),
        .o_vld   (item_vld),
        .o_item  (item)
    );

    ncv_scan u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_vld      (item_vld),
        .i_item     (item),
        .i_out_free (out_free),
        .o_take     (take),
        .o_res_vld  (res_vld),
        .o_res      (res)
    );

    ncv_out_reg u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (res_vld),
        .i_res     (res),
        .o_free    (out_free),
        .o_verdict (o_verdict)
    );
endmodule
